// ----- src/spq_pkg.sv -----
// Shared types and constants for the sorted priority queue.
package spq_pkg;

    localparam int ITEM_W = 16;
    localparam int PRIO_W = 8;
    localparam int OCC_W  = 8;

    typedef logic [1:0] t_status;

    localparam t_status ST_INSERTED = 2'd0;
    localparam t_status ST_REMOVED  = 2'd1;
    localparam t_status ST_FULL     = 2'd2;
    localparam t_status ST_EMPTY    = 2'd3;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_REMOVE = 1'b1;

    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [ITEM_W-1:0] item;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Controller to datapath
    typedef struct packed {
        logic    load_in;
        logic    rd_prev;
        logic    rd_head;
        logic    shift;
        logic    place;
        logic    pop;
        logic    load_out;
        t_status out_status;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic mode;
        logic full;
        logic empty;
        logic less;
        logic last;
        logic out_free;
    } t_dp_stat;

endpackage

// ----- src/spq_if.sv -----
// Handshake channels for queue operations and their results.
interface spq_in_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [15:0] item_id;
    logic [7:0]  priority_req;

    modport source (output valid, output mode, output item_id, output priority_req,
                    input ready);
    modport sink   (input valid, input mode, input item_id, input priority_req,
                    output ready);
endinterface

interface spq_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] out_item;
    logic [7:0]  out_priority;
    logic [7:0]  occupancy;

    modport source (output valid, output status, output out_item, output out_priority,
                    output occupancy, input ready);
    modport sink   (input valid, input status, input out_item, input out_priority,
                    input occupancy, output ready);
endinterface

// ----- src/spq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module spq_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 128
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/spq_ctrl.sv -----
// Operation sequencer: decode, shift walk, place and pop steps.
module spq_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  spq_pkg::t_dp_stat  i_stat,
    output spq_pkg::t_dp_cmd   o_cmd
);
    import spq_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECIDE = 3'd1;
    localparam logic [2:0] S_SHIFT  = 3'd2;
    localparam logic [2:0] S_PLACE  = 3'd3;
    localparam logic [2:0] S_FRONT  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    t_dp_cmd    cmd;

    always_comb begin
        n_state        = r_state;
        cmd            = '0;
        cmd.out_status = ST_INSERTED;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load_in = 1'b1;
                    n_state     = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_stat.mode == MODE_INSERT) begin
                    if (i_stat.full) begin
                        if (i_stat.out_free) begin
                            cmd.load_out   = 1'b1;
                            cmd.out_status = ST_FULL;
                            n_state        = S_IDLE;
                        end
                    end else if (i_stat.empty) begin
                        n_state = S_PLACE;
                    end else begin
                        cmd.rd_prev = 1'b1;
                        n_state     = S_SHIFT;
                    end
                end else begin
                    if (i_stat.empty) begin
                        if (i_stat.out_free) begin
                            cmd.load_out   = 1'b1;
                            cmd.out_status = ST_EMPTY;
                            n_state        = S_IDLE;
                        end
                    end else begin
                        cmd.rd_head = 1'b1;
                        n_state     = S_FRONT;
                    end
                end
            end
            S_SHIFT: begin
                // move the fetched entry back one place while it outranks the new one
                if (i_stat.less) begin
                    cmd.shift = 1'b1;
                    if (i_stat.last) begin
                        n_state = S_PLACE;
                    end else begin
                        cmd.rd_prev = 1'b1;
                    end
                end else begin
                    n_state = S_PLACE;
                end
            end
            S_PLACE: begin
                if (i_stat.out_free) begin
                    cmd.place      = 1'b1;
                    cmd.load_out   = 1'b1;
                    cmd.out_status = ST_INSERTED;
                    n_state        = S_IDLE;
                end
            end
            S_FRONT: begin
                if (i_stat.out_free) begin
                    cmd.pop        = 1'b1;
                    cmd.load_out   = 1'b1;
                    cmd.out_status = ST_REMOVED;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_cmd      = cmd;

endmodule

// ----- src/spq_dp.sv -----
// Queue datapath: ring-buffer pointers, entry RAM, compare and result register.
module spq_dp #(
    parameter int DEPTH = 128
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  spq_pkg::t_dp_cmd            i_cmd,
    output spq_pkg::t_dp_stat           o_stat,
    input  logic                        i_mode,
    input  logic [spq_pkg::ITEM_W-1:0]  i_item_id,
    input  logic [spq_pkg::PRIO_W-1:0]  i_priority_req,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output spq_pkg::t_status            o_status,
    output logic [spq_pkg::ITEM_W-1:0]  o_out_item,
    output logic [spq_pkg::PRIO_W-1:0]  o_out_priority,
    output logic [spq_pkg::OCC_W-1:0]   o_occupancy
);
    import spq_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    function automatic logic [AW-1:0] f_prev(input logic [AW-1:0] a);
        f_prev = (a == '0) ? AW'(DEPTH - 1) : a - AW'(1);
    endfunction

    function automatic logic [AW-1:0] f_next(input logic [AW-1:0] a);
        f_next = (a == AW'(DEPTH - 1)) ? '0 : a + AW'(1);
    endfunction

    logic              r_mode;
    logic [ITEM_W-1:0] r_item;
    logic [PRIO_W-1:0] r_prio;
    logic [AW-1:0]     r_head;
    logic [CW-1:0]     r_count;
    logic [AW-1:0]     r_hole;
    logic [CW-1:0]     r_pos;

    logic              r_out_valid;
    t_status           r_status;
    logic [ITEM_W-1:0] r_out_item;
    logic [PRIO_W-1:0] r_out_prio;
    logic [OCC_W-1:0]  r_occ;

    logic [CW:0]       tail_sum;
    logic [AW-1:0]     tail;
    logic [AW-1:0]     hole_prev;
    logic [CW-1:0]     n_count;
    logic              we;
    logic [AW-1:0]     raddr;
    t_entry            wdata;
    t_entry            rdata;

    // physical slot one past the last held entry
    assign tail_sum = (CW + 1)'(r_head) + (CW + 1)'(r_count);
    assign tail     = (tail_sum >= (CW + 1)'(DEPTH)) ? AW'(tail_sum - (CW + 1)'(DEPTH))
                                                     : AW'(tail_sum);
    assign hole_prev = f_prev(r_hole);

    assign we    = i_cmd.shift | i_cmd.place;
    assign wdata = i_cmd.place ? t_entry'{prio: r_prio, item: r_item} : rdata;
    assign raddr = i_cmd.rd_head ? r_head : (i_cmd.shift ? f_prev(hole_prev) : hole_prev);

    spq_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_hole),
        .i_wdata (wdata),
        .i_re    (i_cmd.rd_prev | i_cmd.rd_head),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_comb begin
        n_count = r_count;
        if (i_cmd.place) begin
            n_count = r_count + CW'(1);
        end else if (i_cmd.pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_cmd.pop) begin
                r_head <= f_next(r_head);
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_mode <= i_mode;
            r_item <= i_item_id;
            r_prio <= i_priority_req;
            r_hole <= tail;
            r_pos  <= r_count;
        end else if (i_cmd.shift) begin
            r_hole <= hole_prev;
            r_pos  <= r_pos - CW'(1);
        end
        if (i_cmd.load_out) begin
            r_status <= i_cmd.out_status;
            r_occ    <= OCC_W'(n_count);
            if (i_cmd.out_status == ST_REMOVED) begin
                r_out_item <= rdata.item;
                r_out_prio <= rdata.prio;
            end else begin
                r_out_item <= '0;
                r_out_prio <= '0;
            end
        end
    end

    assign o_stat.mode     = r_mode;
    assign o_stat.full     = (r_count == CW'(DEPTH));
    assign o_stat.empty    = (r_count == '0);
    assign o_stat.less     = (r_prio < rdata.prio);
    assign o_stat.last     = (r_pos == CW'(1));
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_out_item     = r_out_item;
    assign o_out_priority = r_out_prio;
    assign o_occupancy    = r_occ;

endmodule

// ----- src/sorted_priority_queue.sv -----
// Sorted priority queue: up to DEPTH (item, priority) entries held in one RAM as a ring
// buffer in ascending priority order, equal priorities in arrival order. Each word on
// the input channel is an insert or a remove and gives exactly one result word. An
// insert moves every held entry of higher priority back one slot at a time through
// the RAM's single write port and single read port, and the walk stops one compare
// after the last entry that moves, or once every held entry has moved. Each result
// waits, in the controller's last step, for the output register to drain. A finished
// result sits in that output register so the next word can be accepted while it
// waits; a later result waits there for it. No clearing pass after reset.
module sorted_priority_queue #(
    parameter int DEPTH = 128
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    spq_in_if.sink    i_in,
    spq_out_if.source o_out
);
    import spq_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    spq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    spq_dp #(
        .DEPTH(DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_mode         (i_in.mode),
        .i_item_id      (i_in.item_id),
        .i_priority_req (i_in.priority_req),
        .i_out_ready    (o_out.ready),
        .o_out_valid    (o_out.valid),
        .o_status       (o_out.status),
        .o_out_item     (o_out.out_item),
        .o_out_priority (o_out.out_priority),
        .o_occupancy    (o_out.occupancy)
    );

    a_full_refusal : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.load_out && cmd.out_status == ST_FULL) |-> stat.full && !stat.mode)
        else $error("full refusal issued while store not full");

    a_empty_refusal : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.load_out && cmd.out_status == ST_EMPTY) |-> stat.empty && stat.mode)
        else $error("empty refusal issued while store holds entries");

    a_shift_insert : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.shift |-> stat.less && !stat.mode && !stat.empty)
        else $error("entry moved outside an insert walk");

    a_result_slot : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> stat.out_free && !(cmd.place && cmd.pop))
        else $error("result loaded over a pending word");

endmodule

// ----- tb/sv/tb_sorted_priority_queue.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the sorted priority queue: directed cases, then random traffic.
module tb_sorted_priority_queue;
    import spq_pkg::*;

    localparam int DEPTH       = 128;
    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 4 * (HOLD_CYCLES + DEPTH + 24);
    localparam int MAX_REPORTS = 40;
    localparam logic [10:0] RX_PATTERN = 11'b10110011101;

    typedef enum int {RX_FREE, RX_RANDOM, RX_PERIODIC} t_rx_style;

    typedef struct packed {
        t_status           status;
        logic [ITEM_W-1:0] item;
        logic [PRIO_W-1:0] prio;
        logic [OCC_W-1:0]  occ;
    } t_queue_reply;

    logic clk;
    logic rst_n;

    spq_in_if  in_ch();
    spq_out_if out_ch();

    sorted_priority_queue #(
        .DEPTH(DEPTH)
    ) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Shadow copy of the queue contents, front entry at index 0.
    logic [PRIO_W-1:0] shadow_prio [DEPTH];
    logic [ITEM_W-1:0] shadow_item [DEPTH];
    int shadow_count = 0;

    t_queue_reply awaited_replies [$];

    int mismatch_count = 0;
    int reply_count    = 0;
    int insert_count   = 0;
    int remove_count   = 0;
    int full_count     = 0;
    int empty_count    = 0;
    int peak_occupancy = 0;

    t_rx_style rx_style     = RX_FREE;
    int        rx_ready_pct = 100;
    int        hold_req_id  = 0;
    int        hold_req_len = 0;
    bit        tx_gaps      = 1'b0;
    int        burst_left   = 0;

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Apply one operation to the shadow queue and return the reply it must produce.
    function automatic t_queue_reply apply_queue_op(logic mode, logic [ITEM_W-1:0] item,
                                                    logic [PRIO_W-1:0] prio);
        t_queue_reply r;
        int pos;
        r = '0;
        if (mode == MODE_INSERT) begin
            if (shadow_count >= DEPTH) begin
                r.status = ST_FULL;
            end else begin
                pos = shadow_count;
                // move back only entries of strictly higher priority, so ties keep arrival order
                while (pos > 0 && prio < shadow_prio[pos-1]) begin
                    shadow_prio[pos] = shadow_prio[pos-1];
                    shadow_item[pos] = shadow_item[pos-1];
                    pos--;
                end
                shadow_prio[pos] = prio;
                shadow_item[pos] = item;
                shadow_count++;
                r.status = ST_INSERTED;
            end
        end else if (shadow_count == 0) begin
            r.status = ST_EMPTY;
        end else begin
            r.status = ST_REMOVED;
            r.item   = shadow_item[0];
            r.prio   = shadow_prio[0];
            for (pos = 1; pos < shadow_count; pos++) begin
                shadow_prio[pos-1] = shadow_prio[pos];
                shadow_item[pos-1] = shadow_item[pos];
            end
            shadow_count--;
        end
        r.occ = OCC_W'(shadow_count);
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // Predict on every accepted word, check every accepted result against the oldest prediction.
    always @(posedge clk) begin
        t_queue_reply want;
        t_queue_reply got;
        if (rst_n && in_ch.valid && in_ch.ready) begin
            want = apply_queue_op(in_ch.mode, in_ch.item_id, in_ch.priority_req);
            awaited_replies.push_back(want);
            case (want.status)
                ST_INSERTED: insert_count++;
                ST_REMOVED:  remove_count++;
                ST_FULL:     full_count++;
                default:     empty_count++;
            endcase
            if (shadow_count > peak_occupancy)
                peak_occupancy = shadow_count;
        end
        if (rst_n && out_ch.valid && out_ch.ready) begin
            got = {out_ch.status, out_ch.out_item, out_ch.out_priority, out_ch.occupancy};
            reply_count++;
            if (awaited_replies.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with none expected", reply_count));
            end else begin
                want = awaited_replies.pop_front();
                if (got.status !== want.status)
                    report_mismatch($sformatf("result %0d status got %0d, expected %0d",
                                              reply_count, got.status, want.status));
                if (got.item !== want.item)
                    report_mismatch($sformatf("result %0d out_item got 0x%0h, expected 0x%0h",
                                              reply_count, got.item, want.item));
                if (got.prio !== want.prio)
                    report_mismatch($sformatf("result %0d out_priority got 0x%0h, expected 0x%0h",
                                              reply_count, got.prio, want.prio));
                if (got.occ !== want.occ)
                    report_mismatch($sformatf("result %0d occupancy got %0d, expected %0d",
                                              reply_count, got.occ, want.occ));
            end
        end
    end

    // Result side: a long hold-off when requested, otherwise the current stall style.
    initial begin : receiver
        int seen_id;
        int hold_left;
        int phase;
        seen_id   = 0;
        hold_left = 0;
        phase     = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req_id != seen_id) begin
                seen_id   = hold_req_id;
                hold_left = hold_req_len;
            end
            if (hold_left > 0) begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end else begin
                case (rx_style)
                    RX_FREE:   out_ch.ready <= 1'b1;
                    RX_RANDOM: out_ch.ready <= ($urandom_range(99) < rx_ready_pct);
                    default:   out_ch.ready <= RX_PATTERN[phase % 11];
                endcase
            end
            phase++;
        end
    end

    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT) begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle = 0;
            else
                idle++;
        end
        $display("[%0t] no word moved for %0d cycles", $realtime, STALL_LIMIT);
        $display("sorted_priority_queue test failed");
        $finish;
    end

    // Offer one word and hold it until accepted; idle between bursts when gaps are on.
    task automatic send_word(logic mode, logic [ITEM_W-1:0] item, logic [PRIO_W-1:0] prio);
        int gap;
        if (tx_gaps && burst_left == 0) begin
            gap = $urandom_range(1, 10);
            @(negedge clk);
            in_ch.valid        <= 1'b0;
            in_ch.mode         <= 1'($urandom_range(1));
            in_ch.item_id      <= ITEM_W'($urandom);
            in_ch.priority_req <= PRIO_W'($urandom);
            repeat (gap - 1) @(negedge clk);
            burst_left = $urandom_range(1, 20);
        end
        @(negedge clk);
        in_ch.valid        <= 1'b1;
        in_ch.mode         <= mode;
        in_ch.item_id      <= item;
        in_ch.priority_req <= prio;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        if (burst_left > 0)
            burst_left--;
    endtask

    task automatic run_queue_traffic(int count, int insert_pct, int prio_span);
        int k;
        logic mode;
        logic [PRIO_W-1:0] prio;
        for (k = 0; k < count; k++) begin
            mode = ($urandom_range(99) < insert_pct) ? MODE_INSERT : MODE_REMOVE;
            case ($urandom_range(9))
                0:       prio = '0;
                1:       prio = '1;
                default: prio = PRIO_W'($urandom_range(prio_span - 1));
            endcase
            send_word(mode, ITEM_W'($urandom_range(16'hFFFF)), prio);
        end
    endtask

    task automatic test_directed_cases();
        rx_style = RX_FREE;
        tx_gaps  = 1'b0;
        send_word(MODE_REMOVE, 16'hFFFF, 8'hFF);   // empty queue refuses
        send_word(MODE_INSERT, 16'h0000, 8'h00);
        send_word(MODE_INSERT, 16'hFFFF, 8'hFF);
        send_word(MODE_INSERT, 16'hA5A5, 8'h80);
        send_word(MODE_INSERT, 16'h5A5A, 8'h80);
        send_word(MODE_INSERT, 16'h1234, 8'h80);
        send_word(MODE_INSERT, 16'h0001, 8'h7F);
        send_word(MODE_INSERT, 16'h8000, 8'hFF);   // ties with the top priority, goes last
        send_word(MODE_INSERT, 16'h7FFF, 8'h00);   // ties with the bottom priority
        repeat (8) send_word(MODE_REMOVE, 16'hC3C3, 8'h3C);
        send_word(MODE_REMOVE, 16'h0000, 8'h00);
        // freed slots come back into use
        send_word(MODE_INSERT, 16'hBEEF, 8'h01);
        send_word(MODE_INSERT, 16'hCAFE, 8'h00);
        send_word(MODE_REMOVE, 16'h0000, 8'h00);
        send_word(MODE_REMOVE, 16'h0000, 8'h00);
        send_word(MODE_REMOVE, 16'h0000, 8'h00);
    endtask

    task automatic test_fill_and_drain();
        rx_style     = RX_RANDOM;
        rx_ready_pct = 60;
        tx_gaps      = 1'b1;
        run_queue_traffic(220, 90, 256);
        run_queue_traffic(220, 10, 256);
        // narrow priorities for long runs of ties
        rx_style = RX_PERIODIC;
        tx_gaps  = 1'b0;
        run_queue_traffic(220, 90, 4);
        run_queue_traffic(220, 10, 4);
    endtask

    task automatic test_mixed_traffic();
        rx_style     = RX_RANDOM;
        rx_ready_pct = 80;
        tx_gaps      = 1'b1;
        run_queue_traffic(250, 55, 256);
        rx_style = RX_FREE;
        run_queue_traffic(100, 50, 16);
    endtask

    task automatic test_output_backpressure();
        rx_style     = RX_FREE;
        tx_gaps      = 1'b0;
        hold_req_len = HOLD_CYCLES;
        hold_req_id++;
        run_queue_traffic(24, 70, 256);
    endtask

    initial begin
        rst_n              = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.mode         = MODE_INSERT;
        in_ch.item_id      = '0;
        in_ch.priority_req = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_cases();
        test_fill_and_drain();
        test_mixed_traffic();
        test_output_backpressure();

        @(negedge clk);
        in_ch.valid <= 1'b0;
        rx_style = RX_FREE;
        while (awaited_replies.size() != 0) @(posedge clk);
        // let any late result show up before closing
        repeat (DEPTH + 8) @(posedge clk);

        $display("covered %0d results: %0d inserts, %0d removes, %0d refused full, %0d refused empty",
                 reply_count, insert_count, remove_count, full_count, empty_count);
        $display("peak occupancy %0d of %0d, ties, long output hold-off; %0d mismatches",
                 peak_occupancy, DEPTH, mismatch_count);
        if (mismatch_count == 0) begin
            $display("sorted_priority_queue test passed");
        end else begin
            $display("sorted_priority_queue test failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
src/spq_pkg.sv
src/spq_if.sv
src/spq_ram.sv
src/spq_ctrl.sv
src/spq_dp.sv
src/sorted_priority_queue.sv
tb/sv/tb_sorted_priority_queue.sv
